// ===== design/mlpsig_pkg.sv =====
// Shared types, constants and the sigmoid table of the perceptron inference block.
package mlpsig_pkg;

    // Default sizing of the network stores.
    localparam int DEF_MAX_LAYERS  = 4;
    localparam int DEF_MAX_INPUTS  = 1024;
    localparam int DEF_MAX_NEURONS = 64;

    // Sigmoid table points and command queue depth.
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES + 1);
    localparam int QUEUE_DEPTH = 4;

    // Widest activation index that a command carries (up to 4096 inputs).
    localparam int IDX_W = 12;

    // Request kinds on the input stream, also used as command kinds.
    typedef enum logic [1:0] {
        REQ_WEIGHT = 2'd0,
        REQ_BIAS   = 2'd1,
        REQ_PIXEL  = 2'd2
    } req_e;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LAYER_COUNT = 3'd0,
        CFG_INPUT_SIZE  = 3'd1,
        CFG_LAYER_ONE   = 3'd2,
        CFG_LAYER_TWO   = 3'd3,
        CFG_LAYER_THREE = 3'd4
    } cfg_reg_e;

    // Command passed from the front end to the back end.
    typedef struct packed {
        req_e              kind;
        logic [1:0]        layer;
        logic [5:0]        neuron;
        logic [IDX_W-1:0]  index;
        logic [15:0]       value;
        logic              last;
    } cmd_t;

    // Clamped configuration seen by both ends.
    typedef struct packed {
        logic [2:0]  layer_count;
        logic [12:0] input_count;
        logic [6:0]  size_one;
        logic [6:0]  size_two;
        logic [6:0]  size_three;
    } cfg_t;

    typedef logic [15:0] sig_tab_t [0:SIG_ENTRIES];

    // Builds the sigmoid points at elaboration. e^-|v| is a product of
    // per-bit factors in Q31; the quotient is formed by long division.
    function automatic sig_tab_t build_sig_table();
        sig_tab_t    t;
        logic [63:0] fac [16];
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        int          v;
        int          a;
        fac[0] = 64'd2146959424;
        for (int b = 1; b < 16; b++) begin
            fac[b] = (fac[b-1] * fac[b-1] + (64'd1 << 30)) >> 31;
        end
        for (int i = 0; i <= SIG_ENTRIES; i++) begin
            v = (i * 65536) / SIG_ENTRIES - 32768;
            a = (v < 0) ? -v : v;
            e = 64'd1 << 31;
            for (int b = 0; b < 16; b++) begin
                if (((a >> b) & 1) != 0) begin
                    e = (e * fac[b] + (64'd1 << 30)) >> 31;
                end
            end
            den = (64'd1 << 31) + e;
            num = (v >= 0) ? (64'd65535 << 31) : (64'd65535 * e);
            num = num + (den >> 1);
            rem = '0;
            q   = '0;
            for (int k = 63; k >= 0; k--) begin
                rem = {rem[62:0], num[k]};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[k] = 1'b1;
                end
            end
            t[i] = q[15:0];
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

// ===== design/mlpsig_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mlpsig_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mlpsig_fifo.sv =====
// Short command queue between the front end and the back end.
module mlpsig_fifo
    import mlpsig_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // Pointer advance with wrap at the queue depth.
    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slots[rd_ptr_reg];

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ===== design/mlpsig_front.sv =====
// Front end: accepts requests, filters them and tracks the pixel position.
module mlpsig_front
    import mlpsig_pkg::*;
#(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        push,
    output cmd_t        push_cmd,
    input  logic        full
);

    localparam int CALC_LAYERS = MAX_LAYERS - 1;
    localparam int ROW_LEN     = (MAX_INPUTS > MAX_NEURONS) ? MAX_INPUTS : MAX_NEURONS;
    localparam int PW          = $clog2(MAX_INPUTS) + 1;

    logic [1:0]    layer_index;
    logic [5:0]    neuron_index;
    logic [9:0]    input_index;
    logic [15:0]   param_value;
    logic [7:0]    pixel;
    logic          accept;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] pos_now;
    logic [PW-1:0] pos_inc;
    logic [12:0]   nin;

    assign layer_index  = s_tdata[1:0];
    assign neuron_index = s_tdata[7:2];
    assign input_index  = s_tdata[17:8];
    assign param_value  = s_tdata[33:18];
    assign pixel        = s_tdata[41:34];

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;
    assign nin      = cfg.input_count;

    // Pixel position wraps once a sample is full.
    assign pos_now = (13'(pos_reg) >= nin) ? '0 : pos_reg;
    assign pos_inc = pos_now + PW'(1);

    // Classify the request and build the command for the back end.
    always_comb begin
        push           = 1'b0;
        pos_next       = pos_reg;
        push_cmd.kind  = REQ_PIXEL;
        push_cmd.layer = layer_index;
        push_cmd.neuron = neuron_index;
        push_cmd.index = IDX_W'(input_index);
        push_cmd.value = param_value;
        push_cmd.last  = 1'b0;
        case (s_tuser)
            REQ_WEIGHT: begin
                push_cmd.kind = REQ_WEIGHT;
                push = accept && (layer_index < CALC_LAYERS)
                    && (neuron_index < MAX_NEURONS) && (input_index < ROW_LEN);
            end
            REQ_BIAS: begin
                push_cmd.kind = REQ_BIAS;
                push = accept && (layer_index < CALC_LAYERS)
                    && (neuron_index < MAX_NEURONS);
            end
            REQ_PIXEL: begin
                push_cmd.kind  = REQ_PIXEL;
                push_cmd.index = IDX_W'(pos_now);
                push_cmd.value = {pixel, pixel};
                push_cmd.last  = s_tlast;
                push           = accept;
                if (accept) begin
                    if (s_tlast || (13'(pos_inc) >= nin)) begin
                        pos_next = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    // Pixel position register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== design/mlpsig_back.sv =====
// Back end: executes store writes and runs the layer-by-layer forward pass.
module mlpsig_back
    import mlpsig_pkg::*;
#(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        empty,
    input  cmd_t        pop_cmd,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    localparam int CALC_LAYERS = MAX_LAYERS - 1;
    localparam int ROW_LEN     = (MAX_INPUTS > MAX_NEURONS) ? MAX_INPUTS : MAX_NEURONS;
    localparam int RW          = $clog2(ROW_LEN);
    localparam int NW          = $clog2(MAX_NEURONS);
    localparam int WT_DEPTH    = CALC_LAYERS << (NW + RW);
    localparam int WT_AW       = $clog2(WT_DEPTH);
    localparam int BS_DEPTH    = CALC_LAYERS << NW;
    localparam int BS_AW       = $clog2(BS_DEPTH);
    localparam int AC_DEPTH    = 2 << RW;
    localparam int AC_AW       = RW + 1;
    localparam int ACC_W       = 34 + RW;
    localparam int POS_W       = 16 + SIG_IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_BIAS, S_MAC, S_Z, S_SIG1, S_SIG2, S_ERD, S_EWAIT
    } state_t;

    state_t                   state_reg;
    logic [1:0]               cl_reg;
    logic                     cur_reg;
    logic [6:0]               n_reg;
    logic [RW:0]              j_reg;
    logic                     first_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [32:0]       prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [15:0]              z_reg;
    logic [31:0]              m0_reg;
    logic [31:0]              m1_reg;
    logic [6:0]               m_reg;
    logic                     m_tvalid_reg;
    logic [5:0]               out_neuron_reg;
    logic [15:0]              out_act_reg;
    logic                     m_tlast_reg;

    logic                     wt_we;
    logic [WT_AW-1:0]         wt_waddr;
    logic [WT_AW-1:0]         wt_raddr;
    logic [15:0]              wt_q;
    logic                     bs_we;
    logic [BS_AW-1:0]         bs_waddr;
    logic [BS_AW-1:0]         bs_raddr;
    logic [15:0]              bs_q;
    logic                     ac_we;
    logic [AC_AW-1:0]         ac_waddr;
    logic [15:0]              ac_wdata;
    logic [AC_AW-1:0]         ac_raddr;
    logic [15:0]              ac_q;

    logic [12:0]              prev_size;
    logic [6:0]               cur_size;
    logic                     issue;
    logic [15:0]              z_sat;
    logic [15:0]              u;
    logic [POS_W-1:0]         pos;
    logic [SIG_IDX_W-1:0]     tidx;
    logic [15:0]              frac;
    logic [33:0]              interp;
    logic [15:0]              sig_out;
    logic                     out_free;

    // Neuron counts of the computed layers.
    function automatic logic [6:0] layer_size(input cfg_t c, input logic [1:0] k);
        case (k)
            2'd0:    return c.size_one;
            2'd1:    return c.size_two;
            default: return c.size_three;
        endcase
    endfunction

    assign cur_size  = layer_size(cfg, cl_reg);
    assign prev_size = (cl_reg == 2'd0) ? cfg.input_count
                                        : 13'(layer_size(cfg, cl_reg - 2'd1));
    assign issue     = (state_reg == S_MAC) && (13'(j_reg) < prev_size);
    assign pop       = (state_reg == S_IDLE) && !empty;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Store write ports take commands, activation writes also take results.
    assign wt_we    = pop && (pop_cmd.kind == REQ_WEIGHT);
    assign wt_waddr = WT_AW'({pop_cmd.layer, NW'(pop_cmd.neuron), RW'(pop_cmd.index)});
    assign bs_we    = pop && (pop_cmd.kind == REQ_BIAS);
    assign bs_waddr = BS_AW'({pop_cmd.layer, NW'(pop_cmd.neuron)});
    assign ac_we    = (pop && (pop_cmd.kind == REQ_PIXEL)) || (state_reg == S_SIG2);
    assign ac_waddr = (state_reg == S_SIG2) ? {~cur_reg, RW'(n_reg)}
                                            : {1'b0, RW'(pop_cmd.index)};
    assign ac_wdata = (state_reg == S_SIG2) ? sig_out : pop_cmd.value;

    // Read addresses follow the pass counters.
    assign wt_raddr = WT_AW'({cl_reg, NW'(n_reg), RW'(j_reg)});
    assign bs_raddr = BS_AW'({cl_reg, NW'(n_reg)});
    assign ac_raddr = (state_reg == S_MAC) ? {cur_reg, RW'(j_reg)} : {cur_reg, RW'(n_reg)};

    // Floor to Q4.12 and saturate to [-8, 8).
    always_comb begin
        if ((acc_reg[ACC_W-1:31] == '0) || (acc_reg[ACC_W-1:31] == '1)) begin
            z_sat = acc_reg[31:16];
        end else if (acc_reg[ACC_W-1]) begin
            z_sat = 16'h8000;
        end else begin
            z_sat = 16'h7FFF;
        end
    end

    // Table position and interpolation.
    assign u      = {~z_reg[15], z_reg[14:0]};
    assign pos    = POS_W'(u) * POS_W'(SIG_ENTRIES);
    assign tidx   = pos[POS_W-1:16];
    assign frac   = pos[15:0];
    assign interp = 34'(m0_reg) + 34'(m1_reg) + 34'd32768;
    assign sig_out = (interp[33:32] != 2'b00) ? 16'hFFFF : interp[31:16];

    mlpsig_ram #(.WIDTH(16), .DEPTH(WT_DEPTH), .ADDR_W(WT_AW)) u_weight_ram (
        .aclk(aclk), .wr_en(wt_we), .wr_addr(wt_waddr), .wr_data(pop_cmd.value),
        .rd_addr(wt_raddr), .rd_data(wt_q)
    );

    mlpsig_ram #(.WIDTH(16), .DEPTH(BS_DEPTH), .ADDR_W(BS_AW)) u_bias_ram (
        .aclk(aclk), .wr_en(bs_we), .wr_addr(bs_waddr), .wr_data(pop_cmd.value),
        .rd_addr(bs_raddr), .rd_data(bs_q)
    );

    mlpsig_ram #(.WIDTH(16), .DEPTH(AC_DEPTH), .ADDR_W(AC_AW)) u_act_ram (
        .aclk(aclk), .wr_en(ac_we), .wr_addr(ac_waddr), .wr_data(ac_wdata),
        .rd_addr(ac_raddr), .rd_data(ac_q)
    );

    // Pass sequencer, multiply-accumulate pipeline and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cl_reg       <= '0;
            cur_reg      <= 1'b0;
            n_reg        <= '0;
            j_reg        <= '0;
            first_reg    <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            if (v1_reg) begin
                prod_reg <= $signed({1'b0, ac_q}) * $signed(wt_q);
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop && (pop_cmd.kind == REQ_PIXEL) && pop_cmd.last) begin
                        cl_reg    <= '0;
                        cur_reg   <= 1'b0;
                        n_reg     <= '0;
                        state_reg <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    j_reg     <= '0;
                    first_reg <= 1'b1;
                    state_reg <= S_MAC;
                end
                S_MAC: begin
                    first_reg <= 1'b0;
                    if (first_reg) begin
                        acc_reg <= ACC_W'($signed(bs_q)) <<< 16;
                    end else if (v2_reg) begin
                        acc_reg <= acc_reg + ACC_W'(prod_reg);
                    end
                    if (issue) begin
                        j_reg <= j_reg + (RW+1)'(1);
                    end else if (!v1_reg && !v2_reg && !first_reg) begin
                        state_reg <= S_Z;
                    end
                end
                S_Z: begin
                    z_reg     <= z_sat;
                    state_reg <= S_SIG1;
                end
                S_SIG1: begin
                    m0_reg    <= 32'(SIG_TABLE[tidx]) * 32'(17'h10000 - {1'b0, frac});
                    m1_reg    <= 32'(SIG_TABLE[tidx + SIG_IDX_W'(1)]) * 32'(frac);
                    state_reg <= S_SIG2;
                end
                S_SIG2: begin
                    if (n_reg + 7'd1 < cur_size) begin
                        n_reg     <= n_reg + 7'd1;
                        state_reg <= S_BIAS;
                    end else if (3'(cl_reg) + 3'd2 < cfg.layer_count) begin
                        cl_reg    <= cl_reg + 2'd1;
                        cur_reg   <= ~cur_reg;
                        n_reg     <= '0;
                        state_reg <= S_BIAS;
                    end else begin
                        cur_reg   <= ~cur_reg;
                        n_reg     <= '0;
                        m_reg     <= cur_size;
                        state_reg <= S_ERD;
                    end
                end
                S_ERD: begin
                    state_reg <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (out_free) begin
                        m_tvalid_reg   <= 1'b1;
                        out_neuron_reg <= n_reg[5:0];
                        out_act_reg    <= ac_q;
                        m_tlast_reg    <= (n_reg + 7'd1 == m_reg);
                        if (n_reg + 7'd1 == m_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            n_reg     <= n_reg + 7'd1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_act_reg, out_neuron_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== design/mlp_sigmoid_inference.sv =====
// Top level of the sigmoid perceptron inference block.
//
// Weight, bias and pixel requests are taken one per cycle while the four-entry
// command queue has room; the back end writes them into block RAM in order.
// A pixel request marked last starts a forward pass, during which the queue
// fills and then holds off further requests. The pass runs one shared
// multiply-accumulate unit fed by the weight and activation RAM read ports:
// each neuron loads its bias, accumulates over the inputs of its layer,
// saturates the sum and looks up and interpolates the sigmoid. The results
// of the last layer are then read out one by one and wait while the result
// stream stalls. The default network is 1024-64-10. Stores are not cleared
// at reset; entries must be written before a pass reads them.
module mlp_sigmoid_inference
    import mlpsig_pkg::*;
#(
    parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
    parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
    parameter int MAX_NEURONS = DEF_MAX_NEURONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // layer_index[1:0], neuron_index[7:2], input_index[17:8],
    // param_value[33:18], pixel[41:34], zero fill[47:42]
    input  logic [47:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_neuron[5:0], out_activation[21:6], zero fill[23:22]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int LAYER_CAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
    localparam int SIZE_CAP  = (MAX_NEURONS < 64) ? MAX_NEURONS : 64;

    logic [2:0]  layer_count_reg;
    logic [10:0] input_size_reg;
    logic [6:0]  size_one_reg;
    logic [6:0]  size_two_reg;
    logic [6:0]  size_three_reg;
    cfg_t        cfg;
    logic        push;
    cmd_t        push_cmd;
    logic        full;
    logic        pop;
    cmd_t        pop_cmd;
    logic        empty;

    // Clamp a layer size into [1, SIZE_CAP].
    function automatic logic [6:0] clamp_size(input logic [6:0] s);
        if (s == 7'd0) begin
            return 7'd1;
        end else if (s > SIZE_CAP) begin
            return 7'(SIZE_CAP);
        end
        return s;
    endfunction

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= 3'd3;
            input_size_reg  <= 11'd1024;
            size_one_reg    <= 7'd64;
            size_two_reg    <= 7'd10;
            size_three_reg  <= 7'd10;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LAYER_COUNT: layer_count_reg <= cfg_data[2:0];
                CFG_INPUT_SIZE:  input_size_reg  <= cfg_data;
                CFG_LAYER_ONE:   size_one_reg    <= cfg_data[6:0];
                CFG_LAYER_TWO:   size_two_reg    <= cfg_data[6:0];
                CFG_LAYER_THREE: size_three_reg  <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Clamped view of the configuration.
    always_comb begin
        if (layer_count_reg < 3'd2) begin
            cfg.layer_count = 3'd2;
        end else if (layer_count_reg > LAYER_CAP) begin
            cfg.layer_count = 3'(LAYER_CAP);
        end else begin
            cfg.layer_count = layer_count_reg;
        end
        if (input_size_reg == 11'd0) begin
            cfg.input_count = 13'd1;
        end else if (13'(input_size_reg) > MAX_INPUTS) begin
            cfg.input_count = 13'(MAX_INPUTS);
        end else begin
            cfg.input_count = 13'(input_size_reg);
        end
        cfg.size_one   = clamp_size(size_one_reg);
        cfg.size_two   = clamp_size(size_two_reg);
        cfg.size_three = clamp_size(size_three_reg);
    end

    mlpsig_front #(
        .MAX_LAYERS(MAX_LAYERS), .MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .push(push), .push_cmd(push_cmd), .full(full)
    );

    mlpsig_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_cmd(push_cmd), .full(full),
        .pop(pop), .pop_cmd(pop_cmd), .empty(empty)
    );

    mlpsig_back #(
        .MAX_LAYERS(MAX_LAYERS), .MAX_INPUTS(MAX_INPUTS), .MAX_NEURONS(MAX_NEURONS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg),
        .empty(empty), .pop_cmd(pop_cmd), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // A request is never queued into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("command pushed into a full queue");

    // The back end never takes a command from an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("command popped from an empty queue");

    // A request of unknown type never enters the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == 2'd3)) |-> !push)
        else $error("unknown request entered the queue");

    // No result is pending right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
